[sv/pca_pkg.sv]
// Package for the per-channel pulse interval averager.
// Holds field widths, register codes and the command and status types shared
// by the controller, the datapath and the top level. Depends on nothing.
`default_nettype none

package pca_pkg;

	localparam int CH_IN_W   = 6;
	localparam int TIME_W    = 32;
	localparam int SUM_W     = 23;
	localparam int CNT_W     = 7;
	localparam int LIMIT_W   = 16;
	localparam int FRAC_W    = 8;
	localparam int MEAN_W    = 24;
	localparam int DIVD_W    = SUM_W + FRAC_W;
	localparam int DATA_W    = 32;
	localparam int ADDR_W    = 3;

	localparam logic [LIMIT_W-1:0] DIFF_LIMIT_RST = 16'd20000;
	localparam logic [CNT_W-1:0]   BATCH_SIZE_RST = 7'd100;

	localparam logic REG_DIFF_LIMIT = 1'b0;
	localparam logic REG_BATCH_SIZE = 1'b1;

	typedef enum logic [1:0] {
		WR_NONE,
		WR_START,
		WR_ADD,
		WR_CLEAR
	} wr_kind_t;

	typedef struct packed {
		logic [CNT_W-1:0]  pulse_count;
		logic [TIME_W-1:0] prev_arrival;
		logic [SUM_W-1:0]  interval_sum;
		logic [CNT_W-1:0]  valid_count;
	} entry_t;

	typedef struct packed {
		logic     capture;
		wr_kind_t wr_kind;
		logic     div_start;
		logic     out_load;
	} cmd_t;

	typedef struct packed {
		logic ch_ok;
		logic n_zero;
		logic n_full;
		logic div_busy;
		logic out_free;
	} sts_t;

endpackage

`default_nettype wire

[sv/pca_div.sv]
// Restoring radix-2 divider producing one quotient bit per cycle.
// Divides the scaled interval sum by the valid-difference count.
// Depends on pca_pkg for the operand widths.
`default_nettype none

module pca_div (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire logic [pca_pkg::DIVD_W-1:0] dividend,
	input  wire logic [pca_pkg::CNT_W-1:0]  divisor,
	output logic                            busy,
	output logic [pca_pkg::DIVD_W-1:0]      quotient
);
	import pca_pkg::*;

	localparam int STEP_W = $clog2(DIVD_W + 1);

	logic [CNT_W-1:0]  rem_q;
	logic [CNT_W-1:0]  dvs_q;
	logic [DIVD_W-1:0] quo_q;
	logic [STEP_W-1:0] step_q;
	logic              busy_q;
	logic [CNT_W:0]    shifted;
	logic [CNT_W:0]    trial;
	logic              take;

	always_comb begin
		shifted = {rem_q, quo_q[DIVD_W-1]};
		trial   = shifted - {1'b0, dvs_q};
		take    = shifted >= {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= STEP_W'(DIVD_W);
		end else if (busy_q) begin
			step_q <= step_q - 1'b1;
			if (step_q == STEP_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvs_q <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= take ? trial[CNT_W-1:0] : shifted[CNT_W-1:0];
			quo_q <= {quo_q[DIVD_W-2:0], take};
		end
	end

	assign busy     = busy_q;
	assign quotient = quo_q;

endmodule

`default_nettype wire

[sv/pca_dp.sv]
// Datapath: per-channel state memory with valid bits, difference check,
// running sum update, divider and the result register.
// Depends on pca_pkg and pca_div.
`default_nettype none

module pca_dp #(
	parameter int CHANNELS = 33
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire pca_pkg::cmd_t               cmd,
	output pca_pkg::sts_t                    sts,
	input  wire logic [pca_pkg::CH_IN_W-1:0] in_channel,
	input  wire logic [pca_pkg::TIME_W-1:0]  in_time,
	input  wire logic [pca_pkg::LIMIT_W-1:0] diff_limit,
	input  wire logic [pca_pkg::CNT_W-1:0]   batch_size,
	input  wire logic                        m_ready,
	output logic                             m_valid,
	output logic [pca_pkg::CH_IN_W-1:0]      m_channel,
	output logic [pca_pkg::TIME_W-1:0]       m_last,
	output logic [pca_pkg::MEAN_W-1:0]       m_mean,
	output logic                             m_none
);
	import pca_pkg::*;

	localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	entry_t              mem [CHANNELS];
	logic [CHANNELS-1:0] valid_q;

	logic [CH_IN_W-1:0] ch_q;
	logic [TIME_W-1:0]  t_q;
	entry_t             rd_q;
	logic               rdv_q;

	logic [CH_IN_W-1:0] hold_ch_q;
	logic [TIME_W-1:0]  hold_last_q;
	logic               hold_none_q;

	logic               m_valid_q;
	logic [CH_IN_W-1:0] m_channel_q;
	logic [TIME_W-1:0]  m_last_q;
	logic [MEAN_W-1:0]  m_mean_q;
	logic               m_none_q;

	logic [CH_W-1:0]   rd_idx;
	logic [CH_W-1:0]   wr_idx;
	logic [CNT_W-1:0]  n;
	logic [TIME_W:0]   diff;
	logic              diff_good;
	entry_t            wdata;
	logic              wr_en;
	logic              div_busy;
	logic [DIVD_W-1:0] quotient;

	always_comb begin
		rd_idx    = CH_W'(in_channel);
		wr_idx    = CH_W'(ch_q);
		n         = rdv_q ? rd_q.pulse_count : '0;
		diff      = {1'b0, t_q} - {1'b0, rd_q.prev_arrival};
		diff_good = !diff[TIME_W] && (diff[TIME_W-1:0] != '0)
			&& (diff[TIME_W-1:0] < {{(TIME_W-LIMIT_W){1'b0}}, diff_limit});
		wdata     = rd_q;
		wr_en     = 1'b0;
		case (cmd.wr_kind)
			WR_START: begin
				wr_en              = 1'b1;
				wdata.pulse_count  = CNT_W'(1);
				wdata.prev_arrival = t_q;
				wdata.interval_sum = '0;
				wdata.valid_count  = '0;
			end
			WR_ADD: begin
				wr_en              = 1'b1;
				wdata.pulse_count  = n + 1'b1;
				wdata.prev_arrival = t_q;
				if (diff_good) begin
					wdata.interval_sum = rd_q.interval_sum + diff[SUM_W-1:0];
					wdata.valid_count  = rd_q.valid_count + 1'b1;
				end
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			ch_q <= in_channel;
			t_q  <= in_time;
			rd_q <= mem[rd_idx];
		end
		if (wr_en) begin
			mem[wr_idx] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			rdv_q   <= 1'b0;
		end else begin
			if (cmd.capture) begin
				rdv_q <= valid_q[rd_idx];
			end
			if (wr_en) begin
				valid_q[wr_idx] <= 1'b1;
			end else if (cmd.wr_kind == WR_CLEAR) begin
				valid_q[wr_idx] <= 1'b0;
			end
		end
	end

	pca_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend ({rd_q.interval_sum, {FRAC_W{1'b0}}}),
		.divisor  (rd_q.valid_count),
		.busy     (div_busy),
		.quotient (quotient)
	);

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			hold_ch_q   <= ch_q;
			hold_last_q <= rd_q.prev_arrival;
			hold_none_q <= (rd_q.valid_count == '0);
		end
		if (cmd.out_load) begin
			m_channel_q <= hold_ch_q;
			m_last_q    <= hold_last_q;
			m_mean_q    <= hold_none_q ? '0 : quotient[MEAN_W-1:0];
			m_none_q    <= hold_none_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			m_valid_q <= 1'b1;
		end else if (m_ready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_comb begin
		sts.ch_ok    = 32'(ch_q) < CHANNELS;
		sts.n_zero   = (n == '0);
		sts.n_full   = (n >= batch_size);
		sts.div_busy = div_busy;
		sts.out_free = !m_valid_q || m_ready;
	end

	assign m_valid   = m_valid_q;
	assign m_channel = m_channel_q;
	assign m_last    = m_last_q;
	assign m_mean    = m_mean_q;
	assign m_none    = m_none_q;

	property p_write_in_range;
		@(posedge clk) disable iff (!arst_n)
		(cmd.wr_kind != WR_NONE) |-> (32'(ch_q) < CHANNELS);
	endproperty
	a_write_in_range: assert property (p_write_in_range)
		else $error("state write to a channel outside the table");

	property p_start_sets_valid;
		@(posedge clk) disable iff (!arst_n)
		(cmd.wr_kind == WR_START) |=> valid_q[$past(wr_idx)];
	endproperty
	a_start_sets_valid: assert property (p_start_sets_valid)
		else $error("batch start did not mark the channel as holding state");

endmodule

`default_nettype wire

[sv/pca_ctrl.sv]
// Controller state machine: accepts an item, steers the state update and
// sequences the divide and the result load. Depends on pca_pkg.
`default_nettype none

module pca_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire pca_pkg::sts_t sts,
	output pca_pkg::cmd_t      cmd
);
	import pca_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EVAL,
		ST_DIV
	} state_t;

	state_t state_q;

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			ST_EVAL: begin
				if (sts.ch_ok) begin
					if (sts.n_zero) begin
						cmd.wr_kind = WR_START;
					end else if (!sts.n_full) begin
						cmd.wr_kind = WR_ADD;
					end else begin
						cmd.wr_kind   = WR_CLEAR;
						cmd.div_start = 1'b1;
					end
				end
			end
			ST_DIV: begin
				cmd.out_load = !sts.div_busy && sts.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_EVAL;
					end
				end
				ST_EVAL: begin
					if (sts.ch_ok && !sts.n_zero && sts.n_full) begin
						state_q <= ST_DIV;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_DIV: begin
					if (!sts.div_busy && sts.out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_load_after_divide: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!sts.div_busy && sts.out_free))
		else $error("result loaded while the divider runs or the register is full");

	a_full_enters_divide: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |=> (state_q == ST_DIV) && sts.div_busy)
		else $error("divide start not followed by the divide wait");

	a_no_accept_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !cmd.capture)
		else $error("item captured while the previous item is still at work");

endmodule

`default_nettype wire

[sv/per_channel_pri_averager.sv]
// Top level of the per-channel pulse interval averager: configuration
// registers, stream ports and the controller and datapath instances.
// Depends on pca_pkg, pca_ctrl, pca_dp and pca_div.
//
//   port group   role     fields (lowest bit first)
//   s_*          input    tuser: channel[5:0]; tdata: arrival_time[31:0]
//   m_*          output   tuser: out_channel[5:0], none_valid[6];
//                         tdata: last_arrival[31:0], mean_interval[55:32]
//   p*           config   diff_limit at 0x0, batch_size at 0x4
//
// An item that does not close a batch is accepted with the state memory read,
// then checked and written back. An item that closes a batch then runs the
// one-bit-per-cycle divider and, once it is done, loads the result.
// The result register lets the next item in while a result waits; a further
// result waits in the divide state until the register is taken.
// Reset clears the per-channel valid bits at once; there is no clearing pass.
`default_nettype none

module per_channel_pri_averager #(
	parameter int CHANNELS = 33
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        s_tvalid,
	output logic                             s_tready,
	input  wire logic [31:0]                 s_tdata,  // arrival_time[31:0]
	input  wire logic [7:0]                  s_tuser,  // channel[5:0], unused[7:6]
	output logic                             m_tvalid,
	input  wire logic                        m_tready,
	output logic [63:0]                      m_tdata,  // last_arrival, mean_interval, zero
	output logic [7:0]                       m_tuser,  // out_channel, none_valid, zero
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [pca_pkg::ADDR_W-1:0]  paddr,
	input  wire logic [pca_pkg::DATA_W-1:0]  pwdata,
	output logic [pca_pkg::DATA_W-1:0]       prdata,
	output logic                             pready
);
	import pca_pkg::*;

	logic [LIMIT_W-1:0] diff_limit_q;
	logic [CNT_W-1:0]   batch_size_q;
	logic               cfg_wr;
	cmd_t               cmd;
	sts_t               sts;
	logic [CH_IN_W-1:0] m_channel;
	logic [TIME_W-1:0]  m_last;
	logic [MEAN_W-1:0]  m_mean;
	logic               m_none;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			diff_limit_q <= DIFF_LIMIT_RST;
			batch_size_q <= BATCH_SIZE_RST;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_DIFF_LIMIT: diff_limit_q <= pwdata[LIMIT_W-1:0];
				REG_BATCH_SIZE: batch_size_q <= pwdata[CNT_W-1:0];
				default: begin
					diff_limit_q <= diff_limit_q;
				end
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_DIFF_LIMIT: prdata = {{(DATA_W-LIMIT_W){1'b0}}, diff_limit_q};
			REG_BATCH_SIZE: prdata = {{(DATA_W-CNT_W){1'b0}}, batch_size_q};
			default:        prdata = '0;
		endcase
	end

	pca_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	pca_dp #(
		.CHANNELS (CHANNELS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.in_channel (s_tuser[CH_IN_W-1:0]),
		.in_time    (s_tdata),
		.diff_limit (diff_limit_q),
		.batch_size (batch_size_q),
		.m_ready    (m_tready),
		.m_valid    (m_tvalid),
		.m_channel  (m_channel),
		.m_last     (m_last),
		.m_mean     (m_mean),
		.m_none     (m_none)
	);

	assign m_tdata = {{(64-TIME_W-MEAN_W){1'b0}}, m_mean, m_last};
	assign m_tuser = {{(8-CH_IN_W-1){1'b0}}, m_none, m_channel};

endmodule

`default_nettype wire

[sim/pri_mean_checker.sv]
// Checker for the per-channel pulse interval averager: watches the pulse,
// result and register ports, predicts each batch mean and compares it.
// Depends on pca_pkg.
`timescale 1ns / 100ps

module pri_mean_checker #(
	parameter int CHANNELS = 33
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        s_tvalid,
	input  wire logic                        s_tready,
	input  wire logic [31:0]                 s_tdata,  // arrival_time[31:0]
	input  wire logic [7:0]                  s_tuser,  // channel[5:0], unused[7:6]
	input  wire logic                        m_tvalid,
	input  wire logic                        m_tready,
	input  wire logic [63:0]                 m_tdata,  // last_arrival[31:0], mean_interval[55:32]
	input  wire logic [7:0]                  m_tuser,  // out_channel[5:0], none_valid[6]
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [pca_pkg::ADDR_W-1:0]  paddr,
	input  wire logic [pca_pkg::DATA_W-1:0]  pwdata,
	input  wire logic                        pready,
	output int                               fail_count,
	output int                               pending,
	output int                               result_count
);
	import pca_pkg::*;

	typedef struct packed {
		logic [CH_IN_W-1:0] ch;
		logic [TIME_W-1:0]  last;
		logic [MEAN_W-1:0]  mean;
		logic               none;
	} pri_result_t;

	logic [CNT_W-1:0]   pulses  [CHANNELS];
	logic [TIME_W-1:0]  prev_t  [CHANNELS];
	logic [SUM_W-1:0]   gap_sum [CHANNELS];
	logic [CNT_W-1:0]   gap_cnt [CHANNELS];
	logic [LIMIT_W-1:0] limit_q;
	logic [CNT_W-1:0]   batch_q;
	pri_result_t        mean_queue [$];

	task automatic fold_pulse(input logic [CH_IN_W-1:0] ch, input logic [TIME_W-1:0] t);
		longint      d;
		longint      q;
		int          c;
		pri_result_t r;
		c = ch;
		if (c < CHANNELS) begin
			if (pulses[c] == 0) begin
				prev_t[c]  = t;
				gap_sum[c] = '0;
				gap_cnt[c] = '0;
				pulses[c]  = 1;
			end else if (pulses[c] < batch_q) begin
				d = longint'(t) - longint'(prev_t[c]);
				if (d > 0 && d < longint'(limit_q)) begin
					gap_sum[c] = gap_sum[c] + d[SUM_W-1:0];
					gap_cnt[c] = gap_cnt[c] + 1'b1;
				end
				prev_t[c] = t;
				pulses[c] = pulses[c] + 1'b1;
			end else begin
				r.ch   = ch;
				r.last = prev_t[c];
				r.none = (gap_cnt[c] == 0);
				q = 0;
				if (!r.none)
					q = (longint'(gap_sum[c]) << FRAC_W) / longint'(gap_cnt[c]);
				r.mean = q[MEAN_W-1:0];
				mean_queue.insert(mean_queue.size(), r);
				pulses[c] = '0;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		pri_result_t got;
		pri_result_t want;
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				pulses[i]  = '0;
				prev_t[i]  = '0;
				gap_sum[i] = '0;
				gap_cnt[i] = '0;
			end
			limit_q = DIFF_LIMIT_RST;
			batch_q = BATCH_SIZE_RST;
			mean_queue.delete();
			fail_count   = 0;
			pending      = 0;
			result_count = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				if (paddr[2] == REG_DIFF_LIMIT)
					limit_q = pwdata[LIMIT_W-1:0];
				else
					batch_q = pwdata[CNT_W-1:0];
			end
			if (s_tvalid && s_tready)
				fold_pulse(s_tuser[CH_IN_W-1:0], s_tdata);
			if (m_tvalid && m_tready) begin
				got.ch   = m_tuser[CH_IN_W-1:0];
				got.none = m_tuser[CH_IN_W];
				got.last = m_tdata[TIME_W-1:0];
				got.mean = m_tdata[TIME_W+MEAN_W-1:TIME_W];
				result_count++;
				if (mean_queue.size() == 0) begin
					$error("unexpected result item for channel %0d", got.ch);
					fail_count++;
				end else begin
					want = mean_queue.pop_front();
					if (got.ch !== want.ch) begin
						$error("out_channel: expected %0d, got %0d", want.ch, got.ch);
						fail_count++;
					end
					if (got.last !== want.last) begin
						$error("last_arrival: expected %0d, got %0d", want.last, got.last);
						fail_count++;
					end
					if (got.mean !== want.mean) begin
						$error("mean_interval: expected %0d, got %0d", want.mean, got.mean);
						fail_count++;
					end
					if (got.none !== want.none) begin
						$error("none_valid: expected %0d, got %0d", want.none, got.none);
						fail_count++;
					end
				end
			end
			pending = mean_queue.size();
		end
	end

endmodule

[sim/per_channel_pri_averager_tb.sv]
// Testbench top for the per-channel pulse interval averager: clock, reset,
// pulse and register stimulus, result back-pressure and the verdict.
// Depends on pca_pkg, per_channel_pri_averager and pri_mean_checker.
`timescale 1ns / 100ps

module per_channel_pri_averager_tb;
	import pca_pkg::*;

	localparam int CHANNELS  = 33;
	localparam int WATCHDOG  = 4000;
	localparam int LONG_HOLD = 400;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	logic [31:0]         s_tdata;
	logic [7:0]          s_tuser;
	logic                m_tvalid;
	logic                m_tready;
	logic [63:0]         m_tdata;
	logic [7:0]          m_tuser;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [ADDR_W-1:0]   paddr;
	logic [DATA_W-1:0]   pwdata;
	logic [DATA_W-1:0]   prdata;
	logic                pready;

	int                  fail_count;
	int                  pending;
	int                  result_count;
	int                  idle_cycles = 0;
	int                  pulses_sent = 0;
	int                  cur_limit   = DIFF_LIMIT_RST;
	int                  calm_left [2] = '{0, 0};
	bit                  calm_on   [2];
	bit                  hold_phase = 1'b0;
	bit                  hold_done  = 1'b0;
	logic [31:0]         last_sent [64];

	always #4 clk = ~clk;

	per_channel_pri_averager #(.CHANNELS(CHANNELS)) dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	pri_mean_checker #(.CHANNELS(CHANNELS)) u_checker (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .pready(pready),
		.fail_count(fail_count), .pending(pending), .result_count(result_count)
	);

	// Side 0 paces the pulses, side 1 the results; some stretches run without gaps.
	function automatic int draw_gap(input int side);
		if (calm_left[side] == 0) begin
			calm_left[side] = $urandom_range(8, 40);
			calm_on[side]   = ($urandom_range(0, 3) == 0);
		end
		calm_left[side]--;
		return calm_on[side] ? 0 : $urandom_range(0, 15);
	endfunction

	function automatic logic [31:0] next_arrival(input int ch);
		int k;
		k = $urandom_range(0, 99);
		if (k < 70)
			return last_sent[ch] + $urandom_range(1, (cur_limit > 1) ? cur_limit - 1 : 1);
		else if (k < 78)
			return last_sent[ch];
		else if (k < 86)
			return last_sent[ch] - $urandom_range(1, 1000);
		else if (k < 94)
			return last_sent[ch] + cur_limit + $urandom_range(0, 1000);
		return $urandom;
	endfunction

	task automatic send_item(input int ch, input logic [31:0] t);
		int g;
		g = draw_gap(0);
		if (g > 0) begin
			s_tvalid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= {2'b00, ch[CH_IN_W-1:0]};
		s_tdata  <= t;
		do @(posedge clk); while (!s_tready);
		if (ch < CHANNELS)
			pulses_sent++;
		last_sent[ch] = t;
	endtask

	task automatic write_reg(input logic code, input logic [DATA_W-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {code, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
	endtask

	task automatic configure(input int lim, input int bsz);
		write_reg(REG_DIFF_LIMIT, ($urandom << LIMIT_W) | lim);
		write_reg(REG_BATCH_SIZE, ($urandom << CNT_W) | bsz);
		psel    <= 1'b0;
		penable <= 1'b0;
		cur_limit = lim;
	endtask

	// Lets every expected result drain, then covers the divider of a batch
	// that may still be closing on an item with no result behind it.
	task automatic settle();
		s_tvalid <= 1'b0;
		repeat (2) @(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic run_random(input int n_ch, input int n_items);
		int chans [8];
		int ch;
		for (int i = 0; i < 8; i++)
			chans[i] = $urandom_range(0, CHANNELS - 1);
		repeat (n_items) begin
			if ($urandom_range(0, 19) == 0)
				ch = $urandom_range(CHANNELS, 63);
			else
				ch = chans[$urandom_range(0, n_ch - 1)];
			send_item(ch, next_arrival(ch));
		end
	endtask

	initial begin : sink
		int g;
		m_tready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			g = draw_gap(1);
			if (hold_phase && !hold_done) begin
				g = LONG_HOLD;
				hold_done = 1'b1;
			end
			if (g > 0) begin
				m_tready <= 1'b0;
				repeat (g) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else if (idle_cycles == WATCHDOG) begin
			$display("TB_ERROR");
			$finish;
		end else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin : stimulus
		int rounds;
		rounds = 0;
		for (int i = 0; i < 64; i++)
			last_sent[i] = $urandom;
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		s_tuser  <= '0;
		psel     <= 1'b0;
		penable  <= 1'b0;
		pwrite   <= 1'b0;
		paddr    <= '0;
		pwdata   <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_random(2, 220);
		settle();

		configure(10, 2);
		send_item(0, 32'd0);
		send_item(0, 32'd5);
		send_item(0, 32'd7);
		send_item(1, 32'hFFFF_FFFF);
		send_item(1, 32'd0);
		send_item(1, 32'd1);
		send_item(32, 32'd100);
		send_item(32, 32'd100);
		send_item(32, 32'd0);
		send_item(2, 32'd0);
		send_item(2, 32'd10);
		send_item(2, 32'd11);
		send_item(3, 32'd20);
		send_item(3, 32'd29);
		send_item(3, 32'd30);
		send_item(33, 32'd1);
		send_item(63, 32'hFFFF_FFFF);
		send_item(31, 32'hFFFF_FFF0);
		send_item(31, 32'hFFFF_FFF9);
		send_item(31, 32'd0);
		settle();

		configure(65535, 127);
		run_random(1, 260);
		settle();

		configure(0, 0);
		run_random(4, 60);
		settle();

		configure(1, 1);
		run_random(4, 60);
		settle();

		// The receiver stalls long enough here for the block to back up.
		configure(3000, 2);
		hold_phase = 1'b1;
		run_random(6, 200);
		settle();

		while ((pulses_sent < 1250 || result_count < 60) && rounds < 60) begin
			configure(($urandom_range(0, 3) == 0) ? $urandom_range(1, 65535)
			                                      : $urandom_range(50, 5000),
			          ($urandom_range(0, 7) == 0) ? $urandom_range(2, 127)
			                                      : $urandom_range(2, 10));
			run_random($urandom_range(1, 8), $urandom_range(40, 120));
			settle();
			rounds++;
		end

		if (fail_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
